[hw/rtl/slpi_pkg.sv]
// Shared types, constants and helper functions of the pose integrator.
package slpi_pkg;

   // Operation codes of an input transfer
   localparam logic [1:0] OP_TICK    = 2'd0;
   localparam logic [1:0] OP_VERDICT = 2'd1;
   localparam logic [1:0] OP_SET     = 2'd2;
   localparam logic [1:0] OP_CLEAR   = 2'd3;

   // Register indexes of the write port
   localparam logic [1:0] CSR_STEP_TIME     = 2'd0;
   localparam logic [1:0] CSR_LINEAR_ACCEL  = 2'd1;
   localparam logic [1:0] CSR_ANGULAR_ACCEL = 2'd2;

   localparam logic [15:0] STEP_TIME_RESET     = 16'd655;
   localparam logic [15:0] LINEAR_ACCEL_RESET  = 16'd2560;
   localparam logic [15:0] ANGULAR_ACCEL_RESET = 16'd3840;

   // Angle constants with 30 fraction bits (Q4.30 where 35 bits wide)
   localparam int ATAN_ENTRIES = 24;
   localparam logic [46:0]        TWO_PI_W  = 47'd6746518852;
   localparam logic signed [34:0] TWO_PI_S  = 35'sd6746518852;
   localparam logic signed [34:0] PI_S      = 35'sd3373259426;
   localparam logic signed [34:0] HALF_PI_S = 35'sd1686629713;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic [3:0]         REDUCE_TOP  = 4'd13;

   typedef enum logic [2:0] {
      CD_IDLE,
      CD_REDUCE,
      CD_ADJUST,
      CD_FOLD,
      CD_ROTATE,
      CD_DONE
   } cd_state_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_LACC,
      ST_LSLEW,
      ST_ASLEW,
      ST_HMUL,
      ST_HEAD,
      ST_CSTART,
      ST_CWAIT,
      ST_XH,
      ST_XL,
      ST_XS,
      ST_XA,
      ST_YH,
      ST_YL,
      ST_YS,
      ST_YA,
      ST_FINISH
   } main_state_type;

   typedef struct packed {
      logic               done;
      logic signed [33:0] cos_val;
      logic signed [33:0] sin_val;
   } cd_result_type;

   // Arctangent of 2^-i in Q2.30
   function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
      logic signed [33:0] r;
      case (idx)
         5'd0:    r = 34'sd843314857;
         5'd1:    r = 34'sd497837829;
         5'd2:    r = 34'sd263043837;
         5'd3:    r = 34'sd133525159;
         5'd4:    r = 34'sd67021687;
         5'd5:    r = 34'sd33543516;
         5'd6:    r = 34'sd16775851;
         5'd7:    r = 34'sd8388437;
         5'd8:    r = 34'sd4194283;
         5'd9:    r = 34'sd2097149;
         5'd10:   r = 34'sd1048576;
         5'd11:   r = 34'sd524288;
         5'd12:   r = 34'sd262144;
         5'd13:   r = 34'sd131072;
         5'd14:   r = 34'sd65536;
         5'd15:   r = 34'sd32768;
         5'd16:   r = 34'sd16384;
         5'd17:   r = 34'sd8192;
         5'd18:   r = 34'sd4096;
         5'd19:   r = 34'sd2048;
         5'd20:   r = 34'sd1024;
         5'd21:   r = 34'sd512;
         5'd22:   r = 34'sd256;
         5'd23:   r = 34'sd128;
         default: r = '0;
      endcase
      return r;
   endfunction

   // Clamp a 34-bit sum into 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > 34'sh0_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -34'sh0_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

[hw/rtl/slpi_cordic.sv]
// Angle reduction and iterative rotation-mode CORDIC giving cosine and sine.
module slpi_cordic
   import slpi_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [31:0]  angle,
   output cd_result_type       result
);

   localparam int ITER = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
   localparam logic [4:0] ITER_LAST = 5'(ITER - 1);

   cd_state_type state_ff, state_in;

   logic [46:0]        rem_ff;
   logic               neg_ff;
   logic [3:0]         k_ff;
   logic signed [34:0] red_ff;
   logic               flip_ff;
   logic signed [33:0] x_ff, y_ff, z_ff;
   logic [4:0]         iter_ff;

   logic signed [46:0] z_wide;
   logic [46:0]        cmp_val;
   logic signed [34:0] adj_val;
   logic signed [34:0] adj_red;
   logic signed [33:0] xs, ys, at;

   assign z_wide  = {{1{angle[31]}}, angle, 14'b0};
   assign cmp_val = TWO_PI_W << k_ff;
   assign adj_val = (neg_ff && (rem_ff != '0)) ? (TWO_PI_S - $signed({1'b0, rem_ff[33:0]}))
                                               : $signed({1'b0, rem_ff[33:0]});
   assign adj_red = (adj_val > PI_S) ? (adj_val - TWO_PI_S) : adj_val;
   assign xs = x_ff >>> iter_ff;
   assign ys = y_ff >>> iter_ff;
   assign at = atan_q30(iter_ff);

   // Advance the sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CD_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and result
   always_comb begin
      state_in       = state_ff;
      result.done    = 1'b0;
      result.cos_val = flip_ff ? -x_ff : x_ff;
      result.sin_val = flip_ff ? -y_ff : y_ff;
      case (state_ff)
         CD_IDLE:   if (start) state_in = CD_REDUCE;
         CD_REDUCE: if (k_ff == '0) state_in = CD_ADJUST;
         CD_ADJUST: state_in = CD_FOLD;
         CD_FOLD:   state_in = CD_ROTATE;
         CD_ROTATE: if (iter_ff == ITER_LAST) state_in = CD_DONE;
         CD_DONE: begin
            result.done = 1'b1;
            state_in    = CD_IDLE;
         end
         default:   state_in = CD_IDLE;
      endcase
   end

   // Datapath: one compare-subtract or one rotation per cycle
   always_ff @(posedge clock) begin
      case (state_ff)
         CD_IDLE: begin
            neg_ff <= angle[31];
            rem_ff <= angle[31] ? 47'(-z_wide) : 47'(z_wide);
            k_ff   <= REDUCE_TOP;
         end
         CD_REDUCE: begin
            if (rem_ff >= cmp_val) rem_ff <= rem_ff - cmp_val;
            k_ff <= k_ff - 4'd1;
         end
         CD_ADJUST: begin
            red_ff <= adj_red;
         end
         CD_FOLD: begin
            x_ff    <= CORDIC_GAIN;
            y_ff    <= '0;
            iter_ff <= '0;
            if (red_ff > HALF_PI_S) begin
               z_ff    <= 34'(red_ff - PI_S);
               flip_ff <= 1'b1;
            end else if (red_ff < -HALF_PI_S) begin
               z_ff    <= 34'(red_ff + PI_S);
               flip_ff <= 1'b1;
            end else begin
               z_ff    <= red_ff[33:0];
               flip_ff <= 1'b0;
            end
         end
         CD_ROTATE: begin
            if (!z_ff[33]) begin
               x_ff <= x_ff - ys;
               y_ff <= y_ff + xs;
               z_ff <= z_ff - at;
            end else begin
               x_ff <= x_ff + ys;
               y_ff <= y_ff - xs;
               z_ff <= z_ff + at;
            end
            iter_ff <= iter_ff + 5'd1;
         end
         default: ;
      endcase
   end

endmodule

[hw/rtl/slew_limited_unicycle_pose_integrator_unit.sv]
// A tick's result is loaded after 14 reduction steps, CORDIC_STEPS rotations capped
// at 24, and the shared-multiplier sequence; verdict, set pose and clear skip these
// steps. A result is loaded once the output register is free. One item at a time: the
// next is taken the cycle after the result is loaded, and none is taken before. Reset is
// synchronous: pose, velocities, saved pose and pending clear, registers return to
// their defaults.
module slew_limited_unicycle_pose_integrator_unit
   import slpi_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_wdata,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_operation,
   input  logic signed [15:0]  req_target_linear,
   input  logic signed [15:0]  req_target_angular,
   input  logic                req_collided,
   input  logic signed [31:0]  req_new_x,
   input  logic signed [31:0]  req_new_y,
   input  logic signed [31:0]  req_new_heading,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_pose_x_out,
   output logic signed [31:0]  rsp_pose_y_out,
   output logic signed [31:0]  rsp_heading_out,
   output logic signed [15:0]  rsp_linear_vel_out,
   output logic signed [15:0]  rsp_angular_vel_out,
   output logic                rsp_pending_out,
   output logic                rsp_rolled_back
);

   main_state_type state_ff, state_in;

   logic [15:0] step_time_ff, lin_accel_ff, ang_accel_ff;
   logic signed [31:0] pos_x_ff, pos_y_ff, heading_ff;
   logic signed [31:0] saved_x_ff, saved_y_ff, saved_heading_ff;
   logic signed [15:0] lin_vel_ff, ang_vel_ff;
   logic               pending_ff, rolled_ff;
   logic signed [15:0] tgt_lin_ff, tgt_ang_ff;
   logic signed [32:0] d_ff;
   logic signed [33:0] cos_ff, sin_ff;
   logic signed [51:0] prod_ff;
   logic signed [67:0] acc_ff;
   logic               rsp_valid_ff;
   logic               out_load;
   logic               req_take;

   logic signed [33:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [51:0] mul_p;
   logic signed [33:0] heading_sum;
   logic signed [33:0] pos_sum;
   logic signed [31:0] pos_cur;
   logic               cd_start;
   cd_result_type      cd_res;

   // Move vel toward target by at most step, never past it
   function automatic logic signed [15:0] slew(input logic signed [15:0] vel,
                                               input logic signed [15:0] tgt,
                                               input logic [15:0] step);
      logic signed [17:0] up, dn, r;
      up = 18'(vel) + $signed({2'b0, step});
      dn = 18'(vel) - $signed({2'b0, step});
      if (vel < tgt) begin
         r = (up < 18'(tgt)) ? up : 18'(tgt);
      end else begin
         r = (dn > 18'(tgt)) ? dn : 18'(tgt);
      end
      return r[15:0];
   endfunction

   slpi_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (cd_start),
      .angle  (heading_ff),
      .result (cd_res)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_load  = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);
   assign cd_start  = (state_ff == ST_CSTART);

   // Select operands of the shared multiplier
   always_comb begin
      mul_a = 34'(signed'({1'b0, lin_accel_ff}));
      mul_b = $signed({2'b0, step_time_ff});
      case (state_ff)
         ST_LSLEW: mul_a = 34'(signed'({1'b0, ang_accel_ff}));
         ST_HMUL:  mul_a = 34'(ang_vel_ff);
         ST_HEAD:  mul_a = 34'(lin_vel_ff);
         ST_XH: begin
            mul_a = 34'(d_ff);
            mul_b = 18'($signed(cos_ff[33:17]));
         end
         ST_XL: begin
            mul_a = 34'(d_ff);
            mul_b = $signed({1'b0, cos_ff[16:0]});
         end
         ST_YH: begin
            mul_a = 34'(d_ff);
            mul_b = 18'($signed(sin_ff[33:17]));
         end
         ST_YL: begin
            mul_a = 34'(d_ff);
            mul_b = $signed({1'b0, sin_ff[16:0]});
         end
         default: ;
      endcase
   end

   assign mul_p       = mul_a * mul_b;
   assign heading_sum = 34'(heading_ff) + 34'($signed(prod_ff[32:8]));
   assign pos_cur     = (state_ff == ST_XA) ? pos_x_ff : pos_y_ff;
   assign pos_sum     = 34'(pos_cur) + 34'($signed(acc_ff[67:38]));

   // Advance the sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) state_in = (req_operation == OP_TICK) ? ST_LACC : ST_FINISH;
         end
         ST_LACC:   state_in = ST_LSLEW;
         ST_LSLEW:  state_in = ST_ASLEW;
         ST_ASLEW:  state_in = ST_HMUL;
         ST_HMUL:   state_in = ST_HEAD;
         ST_HEAD:   state_in = ST_CSTART;
         ST_CSTART: state_in = ST_CWAIT;
         ST_CWAIT:  if (cd_res.done) state_in = ST_XH;
         ST_XH:     state_in = ST_XL;
         ST_XL:     state_in = ST_XS;
         ST_XS:     state_in = ST_XA;
         ST_XA:     state_in = ST_YH;
         ST_YH:     state_in = ST_YL;
         ST_YL:     state_in = ST_YS;
         ST_YS:     state_in = ST_YA;
         ST_YA:     state_in = ST_FINISH;
         ST_FINISH: if (out_load) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_time_ff <= STEP_TIME_RESET;
         lin_accel_ff <= LINEAR_ACCEL_RESET;
         ang_accel_ff <= ANGULAR_ACCEL_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_STEP_TIME:     step_time_ff <= csr_wdata;
            CSR_LINEAR_ACCEL:  lin_accel_ff <= csr_wdata;
            CSR_ANGULAR_ACCEL: ang_accel_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Pose, velocity and proposal state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff         <= '0;
         pos_y_ff         <= '0;
         heading_ff       <= '0;
         saved_x_ff       <= '0;
         saved_y_ff       <= '0;
         saved_heading_ff <= '0;
         lin_vel_ff       <= '0;
         ang_vel_ff       <= '0;
         pending_ff       <= 1'b0;
         rolled_ff        <= 1'b0;
      end else begin
         prod_ff <= mul_p;
         case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  rolled_ff  <= 1'b0;
                  pending_ff <= 1'b0;
                  tgt_lin_ff <= req_target_linear;
                  tgt_ang_ff <= req_target_angular;
                  case (req_operation)
                     OP_TICK: begin
                        saved_x_ff       <= pos_x_ff;
                        saved_y_ff       <= pos_y_ff;
                        saved_heading_ff <= heading_ff;
                     end
                     OP_VERDICT: begin
                        // Roll back only a pending proposal that collided
                        if (pending_ff && req_collided) begin
                           pos_x_ff   <= saved_x_ff;
                           pos_y_ff   <= saved_y_ff;
                           heading_ff <= saved_heading_ff;
                           lin_vel_ff <= '0;
                           ang_vel_ff <= '0;
                           rolled_ff  <= 1'b1;
                        end
                     end
                     OP_SET: begin
                        pos_x_ff   <= req_new_x;
                        pos_y_ff   <= req_new_y;
                        heading_ff <= req_new_heading;
                     end
                     default: begin
                        pos_x_ff         <= '0;
                        pos_y_ff         <= '0;
                        heading_ff       <= '0;
                        saved_x_ff       <= '0;
                        saved_y_ff       <= '0;
                        saved_heading_ff <= '0;
                        lin_vel_ff       <= '0;
                        ang_vel_ff       <= '0;
                     end
                  endcase
               end
            end
            ST_LSLEW:  lin_vel_ff <= slew(lin_vel_ff, tgt_lin_ff, prod_ff[31:16]);
            ST_ASLEW:  ang_vel_ff <= slew(ang_vel_ff, tgt_ang_ff, prod_ff[31:16]);
            ST_HEAD:   heading_ff <= sat32(heading_sum);
            ST_CSTART: d_ff <= prod_ff[32:0];
            ST_CWAIT: begin
               cos_ff <= cd_res.cos_val;
               sin_ff <= cd_res.sin_val;
            end
            ST_XL, ST_YL: acc_ff <= 68'(prod_ff) <<< 17;
            ST_XS, ST_YS: acc_ff <= acc_ff + 68'(prod_ff);
            ST_XA:     pos_x_ff <= sat32(pos_sum);
            ST_YA: begin
               pos_y_ff   <= sat32(pos_sum);
               pending_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   // Output register: hold until the transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_pose_x_out      <= pos_x_ff;
         rsp_pose_y_out      <= pos_y_ff;
         rsp_heading_out     <= heading_ff;
         rsp_linear_vel_out  <= lin_vel_ff;
         rsp_angular_vel_out <= ang_vel_ff;
         rsp_pending_out     <= pending_ff;
         rsp_rolled_back     <= rolled_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // A taken item blocks the input until its result is out
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> req_stall)
      else $error("input not stalled after a transfer");

   // A rollback never leaves a proposal pending
   a_rollback_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_rolled_back && rsp_pending_out))
      else $error("rolled back result still pending");

   // CORDIC results arrive only while the sequencer waits for them
   a_cordic_done: assert property (@(posedge clock) disable iff (reset)
      cd_res.done |-> (state_ff == ST_CWAIT))
      else $error("CORDIC finished outside wait state");

endmodule
